/* rtl/emt_pkg.sv */
package emt_pkg;

  localparam int unsigned DAYS_W = 16;
  localparam int unsigned TOD_W  = 17;
  localparam int unsigned SECS_W = 33;
  localparam int unsigned DVD_W  = 64;
  localparam int unsigned DVS_W  = 16;

  localparam int unsigned MUL_STEPS = 20;
  localparam logic [MUL_STEPS-1:0] US_PER_S   = MUL_STEPS'(1000000);
  localparam logic [DVS_W-1:0]     MS_DIVISOR = DVS_W'(1000);
  localparam logic [TOD_W-1:0]     S_PER_DAY  = TOD_W'(86400);
  localparam logic [TOD_W-1:0]     S_PER_HOUR = TOD_W'(3600);
  localparam logic [TOD_W-1:0]     S_PER_MIN  = TOD_W'(60);

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SYNC    = 3'd1,
    OP_SET     = 3'd2,
    OP_READ_US = 3'd3,
    OP_READ_MS = 3'd4,
    OP_CONVERT = 3'd5
  } op_t;

  function automatic logic [8:0] month_start_day(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

/* rtl/emt_date.sv */
module emt_date
  import emt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [6:0]        year_in_century,
  input  logic [3:0]        month,
  input  logic [4:0]        day_of_month,
  input  logic [4:0]        hours,
  input  logic [5:0]        minutes,
  input  logic [5:0]        seconds,
  output logic              done,
  output logic [SECS_W-1:0] secs
);

  logic [3:0]        mon_c;
  logic [3:0]        mon_idx;
  logic              leap_adj;
  logic [10:0]       prev_year;
  logic [8:0]        quarter;
  logic [5:0]        leaps;
  logic [7:0]        years_since;
  logic [DAYS_W-1:0] year_days;
  logic [DAYS_W-1:0] days_next;
  logic [TOD_W-1:0]  tod_next;

  logic              stage1;
  logic [DAYS_W-1:0] days;
  logic [TOD_W-1:0]  tod;

  always_comb begin
    if (month == 4'd0) begin
      mon_c = 4'd1;
    end else if (month > 4'd12) begin
      mon_c = 4'd12;
    end else begin
      mon_c = month;
    end
    mon_idx     = mon_c - 4'd1;
    leap_adj    = (year_in_century[1:0] == 2'd0) && (year_in_century != 7'd100) &&
                  (mon_c > 4'd2);
    prev_year   = 11'd1999 + {4'd0, year_in_century};
    quarter     = prev_year[10:2];
    leaps       = 6'(quarter - 9'd492 - {8'd0, (year_in_century > 7'd100)});
    years_since = 8'd30 + {1'b0, year_in_century};
    year_days   = {8'd0, years_since} * 16'd365;
    days_next   = year_days + {10'd0, leaps} + {7'd0, month_start_day(mon_idx)} +
                  {11'd0, day_of_month} - 16'd1 + {15'd0, leap_adj};
    tod_next    = {12'd0, hours} * S_PER_HOUR + {11'd0, minutes} * S_PER_MIN +
                  {11'd0, seconds};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      done   <= stage1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      days <= days_next;
      tod  <= tod_next;
    end
    if (stage1) begin
      secs <= {17'd0, days} * {16'd0, S_PER_DAY} + {16'd0, tod};
    end
  end

endmodule

/* rtl/emt_divider.sv */
module emt_divider
  import emt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] work;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             qbit;
  logic [DVS_W-1:0] rem_next;

  always_comb begin
    trial = {rem, work[DVD_W-1]};
    qbit  = (trial >= {1'b0, dvs});
    if (qbit) begin
      rem_next = DVS_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= {work[DVD_W-2:0], qbit};
      rem  <= rem_next;
    end
  end

  assign quotient = work;

endmodule

/* rtl/epoch_microsecond_timekeeper.sv */
// Replies (read us, read ms, convert) wait in the reply state while the output stalls.
// One input word at a time; the next word is accepted the cycle after the
// previous one completes. Set and sync wait on the 20-step serial multiply by
// 1e6, and read ms and sync on the 64-step radix-2 divider.
// Synchronous reset clears anchor, counter and synced flag and loads the
// subsecond fraction with 255.
module epoch_microsecond_timekeeper
  import emt_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [14:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [6:0]  year_in_century,
  input  logic [3:0]  month,
  input  logic [4:0]  day_of_month,
  input  logic [4:0]  hours,
  input  logic [5:0]  minutes,
  input  logic [5:0]  seconds,
  input  logic [14:0] subsecond_count,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_value,
  output logic        synced_flag
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DATE  = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_REPLY = 5'b10000
  } state_t;

  localparam int unsigned HI_W = 64 - COUNTER_BITS;
  localparam logic [4:0] MUL_LAST = 5'(MUL_STEPS - 1);

  state_t state;
  state_t state_next;

  logic [63:0]             anchor;
  logic [COUNTER_BITS-1:0] count;
  logic                    synced;
  logic [14:0]             frac;

  op_t         op_q;
  logic [6:0]  year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [4:0]  hours_q;
  logic [5:0]  minutes_q;
  logic [5:0]  seconds_q;
  logic [14:0] sub_q;

  logic [63:0] prod;
  logic [63:0] prod_next;
  logic [63:0] mcand;
  logic [4:0]  bit_idx;
  logic [63:0] res;
  logic [63:0] dvd;
  logic [15:0] dvs;
  logic        date_start;
  logic        div_start;

  logic              date_done;
  logic [SECS_W-1:0] date_secs;
  logic              div_done;
  logic [63:0]       quotient;

  logic        accept;
  logic        out_free;
  logic        mul_last;
  logic [63:0] now;
  logic [34:0] sub_scaled;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign mul_last   = (state == S_MUL) && (bit_idx == MUL_LAST);
  assign now        = anchor + {{HI_W{1'b0}}, count};
  assign prod_next  = US_PER_S[bit_idx] ? (prod + mcand) : prod;
  assign sub_scaled = {15'd0, US_PER_S} * {20'd0, sub_q};

  emt_date u_date (
    .clk             (clk),
    .rst             (rst),
    .start           (date_start),
    .year_in_century (year_q),
    .month           (month_q),
    .day_of_month    (day_q),
    .hours           (hours_q),
    .minutes         (minutes_q),
    .seconds         (seconds_q),
    .done            (date_done),
    .secs            (date_secs)
  );

  emt_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_SYNC, OP_CONVERT: state_next = S_DATE;
            OP_SET:              state_next = S_MUL;
            OP_READ_US:          state_next = S_REPLY;
            OP_READ_MS:          state_next = S_DIV;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_DATE: begin
        if (date_done) begin
          state_next = (op_q == OP_CONVERT) ? S_REPLY : S_MUL;
        end
      end
      S_MUL: begin
        if (mul_last) begin
          state_next = (op_q == OP_SYNC) ? S_DIV : S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = (op_q == OP_SYNC) ? S_IDLE : S_REPLY;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      anchor     <= '0;
      count      <= '0;
      synced     <= 1'b0;
      frac       <= 15'd255;
      date_start <= 1'b0;
      div_start  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      date_start <= accept && ((op == OP_SYNC) || (op == OP_CONVERT));
      div_start  <= (accept && (op == OP_READ_MS)) || (mul_last && (op_q == OP_SYNC));
      if (cfg_write_enable) begin
        frac <= cfg_write_data;
      end
      if (accept && (op == OP_TICK)) begin
        count <= count + 1'b1;
        if (&count) begin
          anchor[63:COUNTER_BITS] <= anchor[63:COUNTER_BITS] + 1'b1;
        end
      end
      if (mul_last && (op_q == OP_SET)) begin
        anchor <= prod_next;
        count  <= '0;
        synced <= 1'b1;
      end
      if ((state == S_DIV) && div_done && (op_q == OP_SYNC)) begin
        anchor <= prod + quotient;
        count  <= '0;
      end
      if ((state == S_REPLY) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op_t'(op);
      year_q    <= year_in_century;
      month_q   <= month;
      day_q     <= day_of_month;
      hours_q   <= hours;
      minutes_q <= minutes;
      seconds_q <= seconds;
      sub_q     <= subsecond_count;
      case (op)
        OP_SET: begin
          mcand   <= {32'd0, epoch_seconds};
          prod    <= '0;
          bit_idx <= '0;
        end
        OP_READ_US: res <= now;
        OP_READ_MS: begin
          dvd <= now;
          dvs <= MS_DIVISOR;
        end
        default: ;
      endcase
    end
    if ((state == S_DATE) && date_done) begin
      res     <= {{(64 - SECS_W){1'b0}}, date_secs};
      mcand   <= {{(64 - SECS_W){1'b0}}, date_secs};
      prod    <= '0;
      bit_idx <= '0;
    end
    if (state == S_MUL) begin
      prod    <= prod_next;
      mcand   <= {mcand[62:0], 1'b0};
      bit_idx <= bit_idx + 5'd1;
      if (mul_last) begin
        dvd <= {29'd0, sub_scaled};
        dvs <= {1'b0, frac} + 16'd1;
      end
    end
    if ((state == S_DIV) && div_done) begin
      res <= quotient;
    end
    if ((state == S_REPLY) && out_free) begin
      result_value <= res;
      synced_flag  <= synced;
    end
  end

endmodule
